// ===== rtl/core/tbs_pkg.sv =====
// Shared constants, beat types and helpers for the two-bit handshake byte sender.
package tbs_pkg;

    localparam int TIMER_BITS  = 24;
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 16;
    localparam int LIMIT_W     = 24;
    localparam int CMP_W       = (TIMER_BITS > LIMIT_W) ? TIMER_BITS : LIMIT_W;
    localparam int CFG_DATA_W  = 24;
    localparam int CFG_INDEX_W = 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_INDEX_W-1:0] CFG_BYTE_COUNT    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIMEOUT_LIMIT = 1'd1;

    localparam logic [COUNT_W-1:0] BYTE_COUNT_RESET    = 16'd1;
    localparam logic [LIMIT_W-1:0] TIMEOUT_LIMIT_RESET = 24'd500000;

    typedef struct packed {
        logic              start_req;
        logic              partner_level;
        logic              byte_valid;
        logic [BYTE_W-1:0] shift_byte;
    } tbs_item_t;

    // Invert, then rotate left by two so the first pair sits at the top.
    function automatic logic [BYTE_W-1:0] tbs_prepare(input logic [BYTE_W-1:0] raw);
        logic [BYTE_W-1:0] inv;
        inv = ~raw;
        return {inv[BYTE_W-3:0], inv[BYTE_W-1:BYTE_W-2]};
    endfunction

endpackage

// ===== rtl/core/tbs_front.sv =====
// Front end: accepts input beats, prepares the byte and queues them for the back end.
module tbs_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               start_req,
    input  logic               partner_level,
    input  logic               byte_valid,
    input  logic [7:0]         byte_value,
    output tbs_pkg::tbs_item_t item,
    output logic               item_valid,
    input  logic               item_pop
);
    import tbs_pkg::*;

    tbs_item_t           entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                push;
    logic                pop;
    tbs_item_t           incoming;

    assign in_ready   = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign item_valid = (count_reg != '0);
    assign item       = entries[rd_ptr_reg];

    assign push = in_valid && in_ready;
    assign pop  = item_pop && item_valid;

    always_comb
    begin
        incoming.start_req     = start_req;
        incoming.partner_level = partner_level;
        incoming.byte_valid    = byte_valid;
        incoming.shift_byte    = tbs_prepare(byte_value);
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= incoming;
        end
    end

endmodule

// ===== rtl/core/tbs_back.sv =====
// Back end: handshake sequencer, configuration registers and the result register.
module tbs_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tbs_pkg::tbs_item_t                   item,
    input  logic                                 item_valid,
    output logic                                 item_pop,
    input  logic                                 cfg_we,
    input  logic [tbs_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [tbs_pkg::CFG_DATA_W-1:0]       cfg_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic                                 read_line,
    output logic                                 sense_line,
    output logic                                 byte_taken,
    output logic                                 busy_res,
    output logic                                 finished,
    output logic                                 timeout_error,
    output logic [tbs_pkg::COUNT_W-1:0]          bytes_sent
);
    import tbs_pkg::*;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_NEED  = 3'd1;
    localparam logic [2:0] PH_LOW   = 3'd2;
    localparam logic [2:0] PH_HIGH  = 3'd3;
    localparam logic [2:0] PH_FINAL = 3'd4;
    localparam logic [2:0] PH_DONE  = 3'd5;
    localparam logic [2:0] PH_ERROR = 3'd6;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    logic [COUNT_W-1:0]    byte_count_reg;
    logic [LIMIT_W-1:0]    timeout_limit_reg;

    logic [2:0]            phase_reg;
    logic [2:0]            phase_next;
    logic [BYTE_W-1:0]     shift_reg;
    logic [BYTE_W-1:0]     shift_next;
    logic [1:0]            pair_reg;
    logic [1:0]            pair_next;
    logic [TIMER_BITS-1:0] wait_reg;
    logic [TIMER_BITS-1:0] wait_next;
    logic [COUNT_W-1:0]    sent_reg;
    logic [COUNT_W-1:0]    sent_next;
    logic                  read_reg;
    logic                  read_next;
    logic                  sense_reg;
    logic                  sense_next;
    logic                  done_reg;
    logic                  done_next;
    logic                  error_reg;
    logic                  error_next;
    logic                  taken_reg;
    logic                  taken_next;
    logic                  out_valid_reg;
    logic                  take;
    logic                  wait_expired;
    logic [COUNT_W-1:0]    sent_inc;

    // Take a beat whenever the result slot is empty or drains this cycle.
    assign take     = item_valid && (!out_valid_reg || out_ready);
    assign item_pop = take;

    assign wait_expired = (CMP_W'(wait_reg) >= CMP_W'(timeout_limit_reg));
    assign sent_inc     = sent_reg + 1'b1;

    always_comb
    begin
        phase_next = phase_reg;
        shift_next = shift_reg;
        pair_next  = pair_reg;
        wait_next  = wait_reg;
        sent_next  = sent_reg;
        read_next  = read_reg;
        sense_next = sense_reg;
        done_next  = done_reg;
        error_next = error_reg;
        taken_next = 1'b0;

        if (item.start_req)
        begin
            sent_next  = '0;
            pair_next  = '0;
            done_next  = 1'b0;
            error_next = 1'b0;
            wait_next  = '0;
            phase_next = (byte_count_reg == '0) ? PH_FINAL : PH_NEED;
        end
        else
        begin
            case (phase_reg)
                PH_NEED:
                begin
                    if (item.byte_valid)
                    begin
                        shift_next = item.shift_byte;
                        pair_next  = '0;
                        wait_next  = '0;
                        phase_next = PH_LOW;
                        taken_next = 1'b1;
                    end
                end
                PH_LOW, PH_HIGH, PH_FINAL:
                begin
                    if ((phase_reg == PH_HIGH) == item.partner_level)
                    begin
                        // Level met: drive the next bit of the pair, or finish.
                        if (phase_reg == PH_LOW)
                        begin
                            read_next  = shift_reg[BYTE_W-1];
                            sense_next = 1'b0;
                            wait_next  = '0;
                            phase_next = PH_HIGH;
                        end
                        else if (phase_reg == PH_HIGH)
                        begin
                            read_next  = shift_reg[BYTE_W-2];
                            sense_next = 1'b1;
                            shift_next = {shift_reg[BYTE_W-3:0], 2'b00};
                            wait_next  = '0;
                            if (pair_reg == 2'd3)
                            begin
                                pair_next  = '0;
                                sent_next  = sent_inc;
                                phase_next = (sent_inc >= byte_count_reg) ? PH_FINAL : PH_NEED;
                            end
                            else
                            begin
                                pair_next  = pair_reg + 1'b1;
                                phase_next = PH_LOW;
                            end
                        end
                        else
                        begin
                            done_next  = 1'b1;
                            phase_next = PH_DONE;
                        end
                    end
                    else if (wait_expired)
                    begin
                        error_next = 1'b1;
                        phase_next = PH_ERROR;
                    end
                    else if (wait_reg != TIMER_MAX)
                    begin
                        wait_next = wait_reg + 1'b1;
                    end
                end
                default:
                begin
                    // Idle, done or error: hold until the next start.
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= BYTE_COUNT_RESET;
            timeout_limit_reg <= TIMEOUT_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BYTE_COUNT:    byte_count_reg    <= cfg_data[COUNT_W-1:0];
                CFG_TIMEOUT_LIMIT: timeout_limit_reg <= cfg_data[LIMIT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            shift_reg     <= '0;
            pair_reg      <= '0;
            wait_reg      <= '0;
            sent_reg      <= '0;
            read_reg      <= 1'b0;
            sense_reg     <= 1'b1;
            done_reg      <= 1'b0;
            error_reg     <= 1'b0;
            taken_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg <= phase_next;
                shift_reg <= shift_next;
                pair_reg  <= pair_next;
                wait_reg  <= wait_next;
                sent_reg  <= sent_next;
                read_reg  <= read_next;
                sense_reg <= sense_next;
                done_reg  <= done_next;
                error_reg <= error_next;
                taken_reg <= taken_next;
            end
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_line     = read_reg;
    assign sense_line    = sense_reg;
    assign byte_taken    = taken_reg;
    assign busy_res      = (phase_reg == PH_NEED) || (phase_reg == PH_LOW) ||
                           (phase_reg == PH_HIGH) || (phase_reg == PH_FINAL);
    assign finished      = done_reg;
    assign timeout_error = error_reg;
    assign bytes_sent    = sent_reg;

    a_error_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg == (phase_reg == PH_ERROR))
        else $error("error flag and phase disagree");

    a_done_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg == (phase_reg == PH_DONE))
        else $error("finished flag and phase disagree");

    a_taken_starts_pair: assert property (@(posedge clk) disable iff (!rst_n)
        taken_reg |-> (phase_reg == PH_LOW) && (pair_reg == 2'd0))
        else $error("byte taken without starting the first pair");

    a_pair_only_in_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (pair_reg != 2'd0) |-> (phase_reg == PH_LOW) || (phase_reg == PH_HIGH) ||
                               (phase_reg == PH_ERROR))
        else $error("pair index left non-zero outside a byte");

    a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> $stable(sent_reg) && $stable(phase_reg) &&
                                        $stable(taken_reg))
        else $error("state advanced while the result beat was stalled");

endmodule

// ===== rtl/core/two_bit_handshake_byte_sender.sv =====
// Top level of the two-bit handshake byte sender: front queue joined to the sequencer.
// A beat goes through a queue entry, then the result register. Throughput: one beat per
// cycle sustained while out_ready holds; the two-entry queue and result register let
// either side stall alone, and the sequencer handles one tick beat per cycle.
// Reset (rst_n, asynchronous, active low) empties the queue, idles the sequencer, drops
// read_line, raises sense_line and loads byte_count 1 and timeout_limit 500000.
module two_bit_handshake_byte_sender (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            start_req,
    input  logic                            partner_level,
    input  logic                            byte_valid,
    input  logic [7:0]                      byte_value,
    input  logic                            cfg_we,
    input  logic [tbs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tbs_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            read_line,
    output logic                            sense_line,
    output logic                            byte_taken,
    output logic                            busy_res,
    output logic                            finished,
    output logic                            timeout_error,
    output logic [15:0]                     bytes_sent
);
    import tbs_pkg::*;

    tbs_item_t item;
    logic      item_valid;
    logic      item_pop;

    tbs_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .start_req     (start_req),
        .partner_level (partner_level),
        .byte_valid    (byte_valid),
        .byte_value    (byte_value),
        .item          (item),
        .item_valid    (item_valid),
        .item_pop      (item_pop)
    );

    tbs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .item_valid    (item_valid),
        .item_pop      (item_pop),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .read_line     (read_line),
        .sense_line    (sense_line),
        .byte_taken    (byte_taken),
        .busy_res      (busy_res),
        .finished      (finished),
        .timeout_error (timeout_error),
        .bytes_sent    (bytes_sent)
    );

endmodule
